/* src/kcl_pkg.sv */
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared types, codes and segment tables of the keypad code lock.
// ----------------------------------------------------------------------------
package kcl_pkg;

	localparam logic       OP_TICK     = 1'b0;
	localparam logic       OP_KEY      = 1'b1;

	localparam logic [2:0] KEY_CONFIRM = 3'd0;
	localparam logic [2:0] KEY_LEFT    = 3'd1;
	localparam logic [2:0] KEY_RIGHT   = 3'd2;
	localparam logic [2:0] KEY_DOWN    = 3'd3;
	localparam logic [2:0] KEY_UP      = 3'd4;

	localparam logic       CFG_FAIL_LIMIT = 1'b0;
	localparam logic       CFG_LOCKOUT    = 1'b1;

	localparam logic [3:0] FAIL_LIMIT_RST = 4'd4;
	localparam logic [7:0] LOCKOUT_RST    = 8'd15;

	localparam logic [2:0] NOT_EDITING = 3'd4;

	localparam logic [1:0] MODE_CODE_LOCKED = 2'd0;
	localparam logic [1:0] MODE_CODE_OPEN   = 2'd1;
	localparam logic [1:0] MODE_CODE_WAIT   = 2'd2;

	localparam logic [7:0] SEG_BLANK       = 8'd0;
	localparam logic [7:0] SEG_MARK_G      = 8'd1;
	localparam logic [7:0] SEG_SYM_LOCKED  = 8'd64;
	localparam logic [7:0] SEG_SYM_OPEN    = 8'd1;
	localparam logic [7:0] SEG_SYM_WAIT    = 8'd72;

	typedef enum logic [2:0] {
		MODE_LOCKED = 3'b001,
		MODE_OPEN   = 3'b010,
		MODE_WAIT   = 3'b100
	} mode_t;

	typedef logic [3:0] digit_t;
	typedef digit_t [3:0] digits_t;
	typedef logic [7:0] seg_t;
	typedef seg_t [7:0] segs_t;

	typedef struct packed {
		mode_t      mode;
		logic [1:0] phase;
		logic [2:0] edit;
		logic [3:0] fails;
		logic [7:0] wait_cnt;
		digits_t    entry;
		digits_t    stored;
	} lock_state_t;

	function automatic seg_t digit_seg(input digit_t d);
		seg_t s;
		unique case (d)
			4'd0:    s = 8'd126;
			4'd1:    s = 8'd48;
			4'd2:    s = 8'd109;
			4'd3:    s = 8'd121;
			4'd4:    s = 8'd51;
			4'd5:    s = 8'd91;
			4'd6:    s = 8'd95;
			4'd7:    s = 8'd112;
			4'd8:    s = 8'd127;
			4'd9:    s = 8'd123;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

	function automatic seg_t spin_seg(input logic [1:0] ph);
		seg_t s;
		unique case (ph)
			2'd0:    s = 8'd64;
			2'd1:    s = 8'd48;
			2'd2:    s = 8'd8;
			default: s = 8'd6;
		endcase
		return s;
	endfunction

	function automatic logic [1:0] mode_code(input mode_t m);
		logic [1:0] c;
		unique case (m)
			MODE_OPEN: c = MODE_CODE_OPEN;
			MODE_WAIT: c = MODE_CODE_WAIT;
			default:   c = MODE_CODE_LOCKED;
		endcase
		return c;
	endfunction

endpackage

/* src/kcl_item_if.sv */
// ----------------------------------------------------------------------------
// kcl_item_if
// Input channel: a tick or key event per beat.
// ----------------------------------------------------------------------------
interface kcl_item_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [2:0] key_code;

	modport source (output valid, output opcode, output key_code, input ready);
	modport sink   (input valid, input opcode, input key_code, output ready);
endinterface

/* src/kcl_result_if.sv */
// ----------------------------------------------------------------------------
// kcl_result_if
// Result channel: lock drive, mode, saved code and eight segment bytes.
// ----------------------------------------------------------------------------
interface kcl_result_if;
	logic        valid;
	logic        ready;
	logic        lock_drive;
	logic [1:0]  mode_now;
	logic        save_strobe;
	logic [15:0] saved_code_out;
	logic [7:0]  seg_pos0;
	logic [7:0]  seg_pos1;
	logic [7:0]  seg_pos2;
	logic [7:0]  seg_pos3;
	logic [7:0]  seg_pos4;
	logic [7:0]  seg_pos5;
	logic [7:0]  seg_pos6;
	logic [7:0]  seg_pos7;

	modport source (
		output valid, output lock_drive, output mode_now, output save_strobe,
		output saved_code_out,
		output seg_pos0, output seg_pos1, output seg_pos2, output seg_pos3,
		output seg_pos4, output seg_pos5, output seg_pos6, output seg_pos7,
		input ready
	);
	modport sink (
		input valid, input lock_drive, input mode_now, input save_strobe,
		input saved_code_out,
		input seg_pos0, input seg_pos1, input seg_pos2, input seg_pos3,
		input seg_pos4, input seg_pos5, input seg_pos6, input seg_pos7,
		output ready
	);
endinterface

/* src/keypad_code_lock_controller.sv */
// ----------------------------------------------------------------------------
// keypad_code_lock_controller
// Four-digit code lock with locked, open and lockout modes and a display.
//
//   channel   dir  handshake     payload
//   item      in   valid/ready   opcode, key_code
//   result    out  valid/ready   lock_drive, mode_now, save_strobe,
//                                saved_code_out, seg_pos0..seg_pos7
//   cfg       in   cfg_we        cfg_index, cfg_wdata
//
// One item per cycle while the result is not stalled.
// An item is registered, then the state update and segment encoding run in
// one combinational pass into the result register.
// Reset puts the lock in the locked mode with the code 0000 and no edit.
// A stalled result holds its register; one more item waits in the input stage.
// ----------------------------------------------------------------------------
module keypad_code_lock_controller (
	input  logic         clk,
	input  logic         arst_n,
	kcl_item_if.sink     item,
	kcl_result_if.source result,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [7:0]   cfg_wdata
);
	import kcl_pkg::*;

	logic        valid_s1;
	logic        opcode_s1;
	logic [2:0]  key_code_s1;
	logic        valid_s2;
	logic        lock_drive_s2;
	logic [1:0]  mode_s2;
	logic        save_s2;
	logic [15:0] code_s2;
	segs_t       segs_s2;

	logic        advance;
	logic        step;
	lock_state_t state_next;
	logic        saved_next;
	segs_t       segs_next;

	assign advance    = !valid_s2 || result.ready;
	assign step       = valid_s1 && advance;
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			opcode_s1   <= item.opcode;
			key_code_s1 <= item.key_code;
		end
	end

	kcl_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.step       (step),
		.opcode     (opcode_s1),
		.key_code   (key_code_s1),
		.state_next (state_next),
		.saved_next (saved_next)
	);

	kcl_display u_display (
		.st   (state_next),
		.segs (segs_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	// load the result beat only when an item actually moves
	always_ff @(posedge clk) begin
		if (step) begin
			lock_drive_s2 <= (state_next.mode == MODE_OPEN);
			mode_s2       <= mode_code(state_next.mode);
			save_s2       <= saved_next;
			code_s2       <= state_next.stored;
			segs_s2       <= segs_next;
		end
	end

	assign result.valid          = valid_s2;
	assign result.lock_drive     = lock_drive_s2;
	assign result.mode_now       = mode_s2;
	assign result.save_strobe    = save_s2;
	assign result.saved_code_out = code_s2;
	assign result.seg_pos0       = segs_s2[0];
	assign result.seg_pos1       = segs_s2[1];
	assign result.seg_pos2       = segs_s2[2];
	assign result.seg_pos3       = segs_s2[3];
	assign result.seg_pos4       = segs_s2[4];
	assign result.seg_pos5       = segs_s2[5];
	assign result.seg_pos6       = segs_s2[6];
	assign result.seg_pos7       = segs_s2[7];

endmodule

/* src/kcl_core.sv */
// ----------------------------------------------------------------------------
// kcl_core
// Lock state, configuration registers and the per-event state update.
// ----------------------------------------------------------------------------
module kcl_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [7:0]           cfg_wdata,
	input  logic                 step,
	input  logic                 opcode,
	input  logic [2:0]           key_code,
	output kcl_pkg::lock_state_t state_next,
	output logic                 saved_next
);
	import kcl_pkg::*;

	lock_state_t state_q;
	lock_state_t st;
	logic [3:0]  fail_limit_q;
	logic [7:0]  lockout_q;
	logic [4:0]  fails_inc;
	logic        same;
	logic [1:0]  idx;
	digit_t      d_cur;

	assign idx   = state_q.edit[1:0];
	assign d_cur = state_q.entry[idx];
	assign same  = (state_q.entry == state_q.stored);
	assign fails_inc = {1'b0, state_q.fails} + 5'd1;

	always_comb begin
		st        = state_q;
		saved_next = 1'b0;
		if (opcode == OP_TICK) begin
			st.phase = state_q.phase + 2'd1;
			if (state_q.mode == MODE_WAIT && st.phase == 2'd3) begin
				if (state_q.wait_cnt == 8'd0) begin
					st.mode = MODE_LOCKED;
				end else begin
					st.wait_cnt = state_q.wait_cnt - 8'd1;
				end
			end
		end else begin
			unique case (key_code)
				KEY_CONFIRM: begin
					if (!state_q.edit[2]) begin
						st.edit = NOT_EDITING;
						if (state_q.mode == MODE_OPEN) begin
							st.stored  = state_q.entry;
							saved_next = 1'b1;
						end
					end else if (state_q.mode == MODE_OPEN) begin
						st.fails = 4'd0;
						st.mode  = MODE_LOCKED;
					end else if (state_q.mode == MODE_LOCKED) begin
						if (same) begin
							st.mode = MODE_OPEN;
						end else if (fails_inc >= {1'b0, fail_limit_q}) begin
							st.fails    = 4'd0;
							st.mode     = MODE_WAIT;
							st.wait_cnt = lockout_q;
						end else begin
							st.fails = fails_inc[3:0];
						end
					end
				end
				KEY_LEFT: begin
					if (state_q.mode != MODE_WAIT) begin
						st.edit = (state_q.edit >= 3'd3) ? 3'd0 : state_q.edit + 3'd1;
					end
				end
				KEY_RIGHT: begin
					if (state_q.mode != MODE_WAIT) begin
						st.edit = (state_q.edit == 3'd0 || state_q.edit[2]) ?
							3'd3 : state_q.edit - 3'd1;
					end
				end
				KEY_DOWN: begin
					if (!state_q.edit[2]) begin
						st.entry[idx] = (d_cur == 4'd0 || d_cur > 4'd9) ? 4'd9 : d_cur - 4'd1;
					end
				end
				KEY_UP: begin
					if (!state_q.edit[2]) begin
						st.entry[idx] = (d_cur >= 4'd9) ? 4'd0 : d_cur + 4'd1;
					end
				end
				default: begin
					// unknown key: report state only
				end
			endcase
		end
	end

	assign state_next = st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode     <= MODE_LOCKED;
			state_q.phase    <= 2'd0;
			state_q.edit     <= NOT_EDITING;
			state_q.fails    <= 4'd0;
			state_q.wait_cnt <= 8'd0;
			state_q.entry    <= '0;
			state_q.stored   <= '0;
		end else if (step) begin
			state_q <= st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_limit_q <= FAIL_LIMIT_RST;
			lockout_q    <= LOCKOUT_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_FAIL_LIMIT) begin
				fail_limit_q <= cfg_wdata[3:0];
			end else begin
				lockout_q <= cfg_wdata;
			end
		end
	end

endmodule

/* src/kcl_display.sv */
// ----------------------------------------------------------------------------
// kcl_display
// Segment encoder: edit view, countdown view and mode symbol.
// ----------------------------------------------------------------------------
module kcl_display (
	input  kcl_pkg::lock_state_t st,
	output kcl_pkg::segs_t       segs
);
	import kcl_pkg::*;

	logic [15:0] prod;
	logic [4:0]  q_ten;
	logic [7:0]  ones_w;
	logic [1:0]  hund;
	logic [4:0]  tens_w;
	logic [2:0]  e3;

	// divide by ten through the reciprocal 205/2048, exact for 8-bit values
	assign prod   = 16'(st.wait_cnt) * 16'd205;
	assign q_ten  = prod[15:11];
	assign ones_w = st.wait_cnt - (8'(q_ten) * 8'd10);
	assign hund   = (q_ten >= 5'd20) ? 2'd2 : ((q_ten >= 5'd10) ? 2'd1 : 2'd0);
	assign tens_w = q_ten - (5'(hund) * 5'd10);
	assign e3     = {1'b0, st.edit[1:0]};

	always_comb begin
		segs = '0;
		if (st.mode == MODE_WAIT) begin
			segs[0] = digit_seg(4'd0);
			segs[1] = digit_seg({2'b00, hund});
			segs[2] = digit_seg(tens_w[3:0]);
			segs[3] = digit_seg(ones_w[3:0]);
			segs[4] = spin_seg(st.phase + 2'd2);
			segs[5] = spin_seg(st.phase + 2'd3);
			segs[6] = spin_seg(st.phase);
			segs[7] = SEG_SYM_WAIT;
		end else begin
			segs[0] = spin_seg(st.phase);
			segs[7] = (st.mode == MODE_OPEN) ? SEG_SYM_OPEN : SEG_SYM_LOCKED;
			if (st.edit[2]) begin
				segs[1] = SEG_BLANK;
				segs[2] = digit_seg(st.entry[0]);
				segs[3] = digit_seg(st.entry[1]);
				segs[4] = digit_seg(st.entry[2]);
				segs[5] = digit_seg(st.entry[3]);
				segs[6] = SEG_BLANK;
			end else begin
				// digit under edit sits at 2+e between marks; others shift around it
				for (int p = 1; p <= 6; p++) begin
					if (3'(p) == e3 + 3'd3 || 3'(p) == e3 + 3'd1) begin
						segs[p] = SEG_MARK_G;
					end else if (3'(p) == e3 + 3'd2) begin
						segs[p] = digit_seg(st.entry[st.edit[1:0]]);
					end else if (3'(p) > e3 + 3'd3) begin
						segs[p] = digit_seg(st.entry[2'(p - 3)]);
					end else begin
						segs[p] = digit_seg(st.entry[2'(p - 1)]);
					end
				end
			end
		end
	end

endmodule

/* tb/sv/kcl_lock_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_lock_checker
// Watches the item, result and register ports of the code lock, keeps its
// own copy of the lock state, predicts each result and compares field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module kcl_lock_checker
	import kcl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	kcl_item_if        item_ch,
	kcl_result_if      res_ch,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_wdata,
	output int         errors,
	output int         pending
);

	typedef struct packed {
		logic        drive;
		logic [1:0]  mode;
		logic        save;
		logic [15:0] code;
		segs_t       seg;
	} lock_view_t;

	localparam seg_t DIGIT_FONT [10] = '{
		8'd126, 8'd48, 8'd109, 8'd121, 8'd51, 8'd91, 8'd95, 8'd112, 8'd127, 8'd123
	};
	localparam seg_t SPIN_FONT [4] = '{8'd64, 8'd48, 8'd8, 8'd6};

	lock_state_t lock_st;
	logic [3:0]  fail_lim;
	logic [7:0]  lock_secs;
	lock_view_t  view_q [$];
	int          err_cnt;

	function automatic seg_t glyph(input digit_t d);
		return (d < 4'd10) ? DIGIT_FONT[d] : SEG_BLANK;
	endfunction

	// Apply one tick or key to the shadow lock and return the view it yields.
	function automatic lock_view_t advance_lock(input logic op, input logic [2:0] key);
		lock_view_t v;
		logic       saved;
		logic [4:0] tries;
		digit_t     d;
		int         cnt;
		int         pos;

		saved = 1'b0;
		if (op == OP_TICK) begin
			lock_st.phase = lock_st.phase + 2'd1;
			if (lock_st.mode == MODE_WAIT && lock_st.phase == 2'd3) begin
				if (lock_st.wait_cnt == 8'd0)
					lock_st.mode = MODE_LOCKED;
				else
					lock_st.wait_cnt = lock_st.wait_cnt - 8'd1;
			end
		end else begin
			case (key)
				KEY_CONFIRM: begin
					if (lock_st.edit < NOT_EDITING) begin
						lock_st.edit = NOT_EDITING;
						if (lock_st.mode == MODE_OPEN) begin
							lock_st.stored = lock_st.entry;
							saved = 1'b1;
						end
					end else if (lock_st.mode == MODE_OPEN) begin
						lock_st.fails = 4'd0;
						lock_st.mode  = MODE_LOCKED;
					end else if (lock_st.mode == MODE_LOCKED) begin
						if (lock_st.entry == lock_st.stored) begin
							lock_st.mode = MODE_OPEN;
						end else begin
							tries = {1'b0, lock_st.fails} + 5'd1;
							if (tries >= {1'b0, fail_lim}) begin
								lock_st.fails    = 4'd0;
								lock_st.mode     = MODE_WAIT;
								lock_st.wait_cnt = lock_secs;
							end else begin
								lock_st.fails = tries[3:0];
							end
						end
					end
				end
				KEY_LEFT: begin
					if (lock_st.mode != MODE_WAIT)
						lock_st.edit = (lock_st.edit >= 3'd3) ? 3'd0 : lock_st.edit + 3'd1;
				end
				KEY_RIGHT: begin
					if (lock_st.mode != MODE_WAIT)
						lock_st.edit = (lock_st.edit == 3'd0 || lock_st.edit >= NOT_EDITING) ?
							3'd3 : lock_st.edit - 3'd1;
				end
				KEY_DOWN, KEY_UP: begin
					if (lock_st.edit < NOT_EDITING) begin
						d = lock_st.entry[lock_st.edit[1:0]];
						if (key == KEY_DOWN)
							d = (d == 4'd0 || d > 4'd9) ? 4'd9 : d - 4'd1;
						else
							d = (d >= 4'd9) ? 4'd0 : d + 4'd1;
						lock_st.entry[lock_st.edit[1:0]] = d;
					end
				end
				default: ;
			endcase
		end

		if (lock_st.mode == MODE_WAIT) begin
			cnt      = lock_st.wait_cnt;
			v.seg[3] = DIGIT_FONT[cnt % 10];
			v.seg[2] = DIGIT_FONT[(cnt / 10) % 10];
			v.seg[1] = DIGIT_FONT[(cnt / 100) % 10];
			v.seg[0] = DIGIT_FONT[0];
			v.seg[6] = SPIN_FONT[lock_st.phase];
			v.seg[5] = SPIN_FONT[lock_st.phase + 2'd3];
			v.seg[4] = SPIN_FONT[lock_st.phase + 2'd2];
			v.seg[7] = SEG_SYM_WAIT;
		end else begin
			v.seg[0] = SPIN_FONT[lock_st.phase];
			v.seg[7] = (lock_st.mode == MODE_OPEN) ? SEG_SYM_OPEN : SEG_SYM_LOCKED;
			if (lock_st.edit >= NOT_EDITING) begin
				v.seg[6] = SEG_BLANK;
				v.seg[5] = glyph(lock_st.entry[3]);
				v.seg[4] = glyph(lock_st.entry[2]);
				v.seg[3] = glyph(lock_st.entry[1]);
				v.seg[2] = glyph(lock_st.entry[0]);
				v.seg[1] = SEG_BLANK;
			end else begin
				// flank the digit under the cursor with a G mark on each side
				pos = 6;
				for (int i = 3; i >= 0; i--) begin
					if (i == lock_st.edit) begin
						v.seg[pos]     = SEG_MARK_G;
						v.seg[pos - 1] = glyph(lock_st.entry[i]);
						v.seg[pos - 2] = SEG_MARK_G;
						pos = pos - 3;
					end else begin
						v.seg[pos] = glyph(lock_st.entry[i]);
						pos = pos - 1;
					end
				end
			end
		end

		case (lock_st.mode)
			MODE_OPEN: v.mode = MODE_CODE_OPEN;
			MODE_WAIT: v.mode = MODE_CODE_WAIT;
			default:   v.mode = MODE_CODE_LOCKED;
		endcase
		v.drive = (lock_st.mode == MODE_OPEN);
		v.save  = saved;
		v.code  = lock_st.stored;
		return v;
	endfunction

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
			err_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		lock_view_t want;
		if (!arst_n) begin
			lock_st.mode     = MODE_LOCKED;
			lock_st.phase    = 2'd0;
			lock_st.edit     = NOT_EDITING;
			lock_st.fails    = 4'd0;
			lock_st.wait_cnt = 8'd0;
			lock_st.entry    = '0;
			lock_st.stored   = '0;
			fail_lim         <= FAIL_LIMIT_RST;
			lock_secs        <= LOCKOUT_RST;
			view_q.delete();
			err_cnt = 0;
			errors  <= 0;
			pending <= 0;
		end else begin
			// results first: the beat arriving now never belongs to this edge's item
			if (res_ch.valid && res_ch.ready) begin
				if (view_q.size() == 0) begin
					$display("%0t: result beat with nothing expected, expected none, got %h",
						$time, res_ch.seg_pos7);
					err_cnt++;
				end else begin
					want = view_q.pop_front();
					check_field("lock_drive", want.drive, res_ch.lock_drive);
					check_field("mode_now", want.mode, res_ch.mode_now);
					check_field("save_strobe", want.save, res_ch.save_strobe);
					check_field("saved_code_out", want.code, res_ch.saved_code_out);
					check_field("seg_pos0", want.seg[0], res_ch.seg_pos0);
					check_field("seg_pos1", want.seg[1], res_ch.seg_pos1);
					check_field("seg_pos2", want.seg[2], res_ch.seg_pos2);
					check_field("seg_pos3", want.seg[3], res_ch.seg_pos3);
					check_field("seg_pos4", want.seg[4], res_ch.seg_pos4);
					check_field("seg_pos5", want.seg[5], res_ch.seg_pos5);
					check_field("seg_pos6", want.seg[6], res_ch.seg_pos6);
					check_field("seg_pos7", want.seg[7], res_ch.seg_pos7);
				end
			end
			if (item_ch.valid && item_ch.ready)
				view_q.push_back(advance_lock(item_ch.opcode, item_ch.key_code));
			if (cfg_we) begin
				if (cfg_index == CFG_FAIL_LIMIT)
					fail_lim <= cfg_wdata[3:0];
				else
					lock_secs <= cfg_wdata;
			end
			errors  <= err_cnt;
			pending <= view_q.size();
		end
	end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the keypad code lock: a directed walk through
// opening, saving, relocking, failing and lockout, then random phases of
// key sequences and tick runs under several register settings, with random
// gaps on both handshakes and one long result stall.
// ----------------------------------------------------------------------------
module tb;
	import kcl_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 70;
	localparam int NUM_PHASES  = 6;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic [7:0] cfg_wdata;
	int         errors;
	int         pending;
	int         sent;
	int         quiet;
	logic       send_calm;
	logic       recv_calm;
	logic       hold_req;

	kcl_item_if   item_ch ();
	kcl_result_if res_ch ();

	keypad_code_lock_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	kcl_lock_checker lock_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_ch   (item_ch),
		.res_ch    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic send_item(input logic op, input logic [2:0] key);
		int gap;
		@(negedge clk);
		if ($urandom_range(0, 31) == 0)
			send_calm = !send_calm;
		gap = send_calm ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid    <= 1'b1;
		item_ch.opcode   <= op;
		item_ch.key_code <= key;
		do @(posedge clk); while (!item_ch.ready);
		sent++;
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Drop valid, wait until every result is back, then let the pipe empty.
	task automatic drain_lock();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_burst();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 28) begin
			repeat ($urandom_range(1, 12)) send_item(OP_TICK, 3'($urandom));
		end else if (pick < 33) begin
			// long tick run to see a lockout count down
			repeat ($urandom_range(30, 70)) send_item(OP_TICK, 3'($urandom));
		end else if (pick < 50) begin
			send_item(OP_KEY, KEY_CONFIRM);
		end else if (pick < 75) begin
			repeat ($urandom_range(1, 2)) begin
				repeat ($urandom_range(1, 3))
					send_item(OP_KEY, $urandom_range(0, 1) ? KEY_LEFT : KEY_RIGHT);
				repeat ($urandom_range(1, 5))
					send_item(OP_KEY, $urandom_range(0, 1) ? KEY_UP : KEY_DOWN);
			end
			send_item(OP_KEY, KEY_CONFIRM);
		end else if (pick < 85) begin
			// spoil one digit, leave the edit, then try it
			send_item(OP_KEY, KEY_LEFT);
			send_item(OP_KEY, KEY_UP);
			send_item(OP_KEY, KEY_CONFIRM);
			send_item(OP_KEY, KEY_CONFIRM);
		end else begin
			repeat ($urandom_range(1, 4)) send_item(1'($urandom), 3'($urandom));
		end
	endtask

	// receiver: random gaps, plus one long hold on request
	initial begin
		int   gap;
		logic held;
		res_ch.ready <= 1'b0;
		recv_calm = 1'b0;
		held      = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 31) == 0)
				recv_calm = !recv_calm;
			gap = recv_calm ? 0 : $urandom_range(0, 15);
			if (hold_req && !held) begin
				gap  = HOLD_CYCLES;
				held = 1'b1;
			end
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	initial begin
		wait (arst_n === 1'b1);
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int lim_tab  [NUM_PHASES];
		int secs_tab [NUM_PHASES];
		int lim;
		int secs;
		int goal;

		lim_tab          = '{1, 15, 3, 0, 4, 4};
		secs_tab         = '{255, 0, 2, 1, 3, 15};
		arst_n           = 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= CFG_FAIL_LIMIT;
		cfg_wdata        <= 8'd0;
		item_ch.valid    <= 1'b0;
		item_ch.opcode   <= OP_TICK;
		item_ch.key_code <= KEY_CONFIRM;
		send_calm        = 1'b0;
		hold_req         = 1'b0;
		sent             = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed walk under the reset settings
		send_item(OP_TICK, 3'd7);
		send_item(OP_KEY, 3'd5);
		send_item(OP_KEY, 3'd7);
		send_item(OP_KEY, KEY_DOWN);
		send_item(OP_KEY, KEY_CONFIRM);
		send_item(OP_KEY, KEY_RIGHT);
		send_item(OP_KEY, KEY_DOWN);
		send_item(OP_KEY, KEY_UP);
		send_item(OP_KEY, KEY_UP);
		send_item(OP_KEY, KEY_LEFT);
		send_item(OP_KEY, KEY_CONFIRM);
		send_item(OP_KEY, KEY_CONFIRM);
		send_item(OP_KEY, KEY_LEFT);
		send_item(OP_KEY, KEY_UP);
		send_item(OP_KEY, KEY_RIGHT);
		send_item(OP_KEY, KEY_CONFIRM);
		send_item(OP_KEY, KEY_CONFIRM);
		drain_lock();

		// limit zero acts as one; zero seconds ends the lockout on the next phase 3
		write_reg(CFG_FAIL_LIMIT, 8'd0);
		write_reg(CFG_LOCKOUT, 8'd0);
		send_item(OP_KEY, KEY_CONFIRM);
		send_item(OP_KEY, KEY_LEFT);
		send_item(OP_KEY, KEY_RIGHT);
		send_item(OP_KEY, KEY_CONFIRM);
		send_item(OP_KEY, KEY_UP);
		repeat (4) send_item(OP_TICK, 3'($urandom));
		drain_lock();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			lim  = lim_tab[ph];
			secs = secs_tab[ph];
			if (ph == 4) begin
				lim  = $urandom_range(0, 15);
				secs = $urandom_range(0, 40);
			end
			// upper nibble of the limit write is don't-care
			write_reg(CFG_FAIL_LIMIT, {4'($urandom), 4'(lim)});
			write_reg(CFG_LOCKOUT, 8'(secs));
			if (ph == 2)
				hold_req = 1'b1;
			goal = sent + PHASE_ITEMS;
			while (sent < goal)
				run_burst();
			drain_lock();
		end

		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
